// ===== src/cstc_pkg.sv =====
`default_nettype none

package cstc_pkg;

  // Longest token length the counter tracks before it saturates
  localparam int unsigned MaxTokenLen = 255;
  localparam int unsigned CountW      = $clog2(MaxTokenLen + 1);
  localparam int unsigned LeadChars   = 5;

  // Result queue between the lexer and the output channel
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QFillW = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    KIND_END      = 4'd0,
    KIND_UNREC    = 4'd1,
    KIND_DECLTYPE = 4'd2,
    KIND_SEP      = 4'd3,
    KIND_NUM      = 4'd4,
    KIND_OP       = 4'd5,
    KIND_SUPP     = 4'd6,
    KIND_DECLKW   = 4'd7,
    KIND_IMPORT   = 4'd8,
    KIND_IDENT    = 4'd9
  } kind_e;

  typedef enum logic [3:0] {
    SYM_NONE   = 4'd0,
    SYM_COLON  = 4'd1,
    SYM_DCOLON = 4'd2,
    SYM_SLASH  = 4'd3,
    SYM_PLUS   = 4'd4,
    SYM_STAR   = 4'd5,
    SYM_MINUS  = 4'd6,
    SYM_BAR    = 4'd7,
    SYM_OROR   = 4'd8,
    SYM_ANDAND = 4'd9,
    SYM_XORXOR = 4'd10,
    SYM_BANG2  = 4'd11,
    SYM_BANG   = 4'd12
  } sym_e;

  typedef struct packed {
    kind_e       kind;
    sym_e        sym;
    logic        neg;
    logic        frac;
    logic [7:0]  len;
    logic        sat;
    logic        last;
  } tok_t;

  // Results of one accepted request, pushed into the queue together
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       first;
    tok_t       second;
  } lex_push_t;

endpackage

`default_nettype wire

// ===== src/cstc_char_if.sv =====
`default_nettype none

interface cstc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== src/cstc_tok_if.sv =====
`default_nettype none

interface cstc_tok_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [3:0] symbol_code;
  logic       number_negative;
  logic       number_has_fraction;
  logic [7:0] token_length;
  logic       length_saturated;
  logic       last_of_run;

  modport source (
    output valid, output token_kind, output symbol_code, output number_negative,
    output number_has_fraction, output token_length, output length_saturated,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input symbol_code, input number_negative,
    input number_has_fraction, input token_length, input length_saturated,
    input last_of_run, output ready
  );
endinterface

`default_nettype wire

// ===== src/cstc_lexer.sv =====
`default_nettype none

module cstc_lexer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          ch_i,
  input  wire logic                end_i,
  output cstc_pkg::lex_push_t      push_o
);

  localparam int unsigned CW = cstc_pkg::CountW;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChBar     = 8'h7C;

  // Keywords packed first character in the low byte
  localparam logic [23:0] KwCst   = 24'h747363;
  localparam logic [23:0] KwFnl   = 24'h6C6E66;
  localparam logic [23:0] KwCls   = 24'h736C63;
  localparam logic [39:0] KwConst = 40'h74736E6F63;
  localparam logic [31:0] KwDest  = 32'h74736564;
  localparam logic [23:0] KwImp   = 24'h706D69;

  typedef enum logic [10:0] {
    MODE_IDLE    = 11'b000_0000_0001,
    MODE_COMMENT = 11'b000_0000_0010,
    MODE_COLON   = 11'b000_0000_0100,
    MODE_MINUS   = 11'b000_0000_1000,
    MODE_INT     = 11'b000_0001_0000,
    MODE_FRAC    = 11'b000_0010_0000,
    MODE_AMP     = 11'b000_0100_0000,
    MODE_CARET   = 11'b000_1000_0000,
    MODE_PIPE    = 11'b001_0000_0000,
    MODE_BANG    = 11'b010_0000_0000,
    MODE_WORD    = 11'b100_0000_0000
  } mode_e;

  typedef struct packed {
    mode_e          mode;
    logic [CW-1:0]  count;
    logic [39:0]    lead;
    logic           minus;
    logic           frac;
    logic           ovf;
  } lex_state_t;

  localparam lex_state_t StReset = '{MODE_IDLE, '0, '0, 1'b0, 1'b0, 1'b0};

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Append one character: keep the leading five, saturate the count
  function automatic lex_state_t add_char(lex_state_t s, logic [7:0] c);
    lex_state_t r;
    r = s;
    if (s.count < CW'(cstc_pkg::LeadChars)) begin
      r.lead = s.lead | ({32'b0, c} << {s.count[2:0], 3'b000});
    end
    if (s.count < CW'(cstc_pkg::MaxTokenLen)) begin
      r.count = s.count + CW'(1);
    end else begin
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  function automatic cstc_pkg::tok_t mk_tok(cstc_pkg::kind_e k, cstc_pkg::sym_e s,
                                            logic [7:0] len);
    cstc_pkg::tok_t t;
    t = '0;
    t.kind = k;
    t.sym  = s;
    t.len  = len;
    return t;
  endfunction

  // Token carrying the collected length, clipped to eight bits
  function automatic cstc_pkg::tok_t len_tok(lex_state_t s, cstc_pkg::kind_e k,
                                             logic neg, logic frac);
    cstc_pkg::tok_t t;
    t      = '0;
    t.kind = k;
    t.sym  = cstc_pkg::SYM_NONE;
    t.neg  = neg;
    t.frac = frac;
    if (32'(s.count) > 32'd255) begin
      t.len = 8'd255;
      t.sat = 1'b1;
    end else begin
      t.len = s.count[7:0];
      t.sat = s.ovf;
    end
    return t;
  endfunction

  function automatic cstc_pkg::tok_t word_tok(lex_state_t s);
    cstc_pkg::kind_e k;
    logic            c3;
    c3 = !s.ovf && (s.count == CW'(3));
    k  = cstc_pkg::KIND_IDENT;
    if ((c3 && (s.lead[23:0] == KwCst || s.lead[23:0] == KwFnl ||
                s.lead[23:0] == KwCls)) ||
        (!s.ovf && s.count == CW'(5) && s.lead == KwConst) ||
        (!s.ovf && s.count == CW'(4) && s.lead[31:0] == KwDest)) begin
      k = cstc_pkg::KIND_DECLKW;
    end else if (c3 && s.lead[23:0] == KwImp) begin
      k = cstc_pkg::KIND_IMPORT;
    end
    return len_tok(s, k, 1'b0, 1'b0);
  endfunction

  // State after a character seen in idle mode
  function automatic lex_state_t start_state(lex_state_t s, logic [7:0] c);
    lex_state_t r;
    r      = s;
    r.mode = MODE_IDLE;
    if (!is_space(c)) begin
      r = StReset;
      priority if (c == ChHash) begin
        r.mode = MODE_COMMENT;
      end else if (c == ChColon) begin
        r.mode = MODE_COLON;
      end else if (c == ChMinus) begin
        r      = add_char(r, c);
        r.mode = MODE_MINUS;
      end else if (c == ChAmp) begin
        r.mode = MODE_AMP;
      end else if (c == ChCaret) begin
        r.mode = MODE_CARET;
      end else if (c == ChBar) begin
        r.mode = MODE_PIPE;
      end else if (c == ChBang) begin
        r.mode = MODE_BANG;
      end else if (is_digit(c)) begin
        r      = add_char(r, c);
        r.mode = MODE_INT;
      end else if (is_letter(c)) begin
        r      = add_char(r, c);
        r.mode = MODE_WORD;
      end else begin
        r.mode = MODE_IDLE;
      end
    end
    return r;
  endfunction

  // Single-character tokens emitted at once from idle mode
  function automatic logic start_emits(logic [7:0] c);
    return !is_space(c) && !is_digit(c) && !is_letter(c) &&
           c != ChHash && c != ChColon && c != ChMinus && c != ChAmp &&
           c != ChCaret && c != ChBar && c != ChBang;
  endfunction

  function automatic cstc_pkg::tok_t start_tok(logic [7:0] c);
    cstc_pkg::tok_t t;
    priority if (c == ChSlash) begin
      t = mk_tok(cstc_pkg::KIND_SEP, cstc_pkg::SYM_SLASH, 8'd1);
    end else if (c == ChPlus) begin
      t = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_PLUS, 8'd1);
    end else if (c == ChStar) begin
      t = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_STAR, 8'd1);
    end else begin
      t = mk_tok(cstc_pkg::KIND_UNREC, cstc_pkg::SYM_NONE, 8'd1);
    end
    return t;
  endfunction

  lex_state_t     st_q, st_d;
  cstc_pkg::tok_t tok_a, tok_b;
  logic           a_v, b_v, restart;
  logic [1:0]     cnt;
  cstc_pkg::tok_t first, second;

  // Close the pending token, then restart on the same character if needed
  always_comb begin
    st_d    = st_q;
    tok_a   = '0;
    tok_b   = '0;
    a_v     = 1'b0;
    b_v     = 1'b0;
    restart = 1'b0;
    if (end_i) begin
      a_v = 1'b1;
      unique case (st_q.mode)
        MODE_COLON: tok_a = mk_tok(cstc_pkg::KIND_DECLTYPE, cstc_pkg::SYM_COLON, 8'd1);
        MODE_MINUS: tok_a = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_MINUS, 8'd1);
        MODE_INT, MODE_FRAC: tok_a = len_tok(st_q, cstc_pkg::KIND_NUM,
                                             st_q.minus, st_q.frac);
        MODE_PIPE:  tok_a = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_BAR, 8'd1);
        MODE_BANG:  tok_a = mk_tok(cstc_pkg::KIND_SUPP, cstc_pkg::SYM_BANG, 8'd1);
        MODE_WORD:  tok_a = word_tok(st_q);
        default:    a_v = 1'b0;
      endcase
      tok_b = mk_tok(cstc_pkg::KIND_END, cstc_pkg::SYM_NONE, 8'd0);
      b_v   = 1'b1;
      st_d  = StReset;
    end else begin
      unique case (st_q.mode)
        MODE_COMMENT: begin
          if (ch_i == ChNewline) st_d.mode = MODE_IDLE;
        end
        MODE_COLON: begin
          a_v = 1'b1;
          if (ch_i == ChColon) begin
            tok_a     = mk_tok(cstc_pkg::KIND_DECLTYPE, cstc_pkg::SYM_DCOLON, 8'd2);
            st_d.mode = MODE_IDLE;
          end else begin
            tok_a   = mk_tok(cstc_pkg::KIND_DECLTYPE, cstc_pkg::SYM_COLON, 8'd1);
            restart = 1'b1;
          end
        end
        MODE_MINUS: begin
          if (is_digit(ch_i)) begin
            st_d       = add_char(st_q, ch_i);
            st_d.minus = 1'b1;
            st_d.mode  = MODE_INT;
          end else begin
            a_v     = 1'b1;
            tok_a   = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_MINUS, 8'd1);
            restart = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(ch_i)) begin
            st_d = add_char(st_q, ch_i);
          end else if (ch_i == ChDot) begin
            st_d      = add_char(st_q, ch_i);
            st_d.frac = 1'b1;
            st_d.mode = MODE_FRAC;
          end else begin
            a_v     = 1'b1;
            tok_a   = len_tok(st_q, cstc_pkg::KIND_NUM, st_q.minus, st_q.frac);
            restart = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(ch_i)) begin
            st_d = add_char(st_q, ch_i);
          end else begin
            a_v     = 1'b1;
            tok_a   = len_tok(st_q, cstc_pkg::KIND_NUM, st_q.minus, st_q.frac);
            restart = 1'b1;
          end
        end
        MODE_AMP: begin
          a_v       = (ch_i == ChAmp);
          tok_a     = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_ANDAND, 8'd2);
          st_d.mode = MODE_IDLE;
        end
        MODE_CARET: begin
          a_v       = (ch_i == ChCaret);
          tok_a     = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_XORXOR, 8'd2);
          st_d.mode = MODE_IDLE;
        end
        MODE_PIPE: begin
          a_v = 1'b1;
          if (ch_i == ChBar) begin
            tok_a     = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_OROR, 8'd2);
            st_d.mode = MODE_IDLE;
          end else begin
            tok_a   = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_BAR, 8'd1);
            restart = 1'b1;
          end
        end
        MODE_BANG: begin
          a_v = 1'b1;
          if (ch_i == ChBang) begin
            tok_a     = mk_tok(cstc_pkg::KIND_OP, cstc_pkg::SYM_BANG2, 8'd2);
            st_d.mode = MODE_IDLE;
          end else begin
            tok_a   = mk_tok(cstc_pkg::KIND_SUPP, cstc_pkg::SYM_BANG, 8'd1);
            restart = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_letter(ch_i)) begin
            st_d = add_char(st_q, ch_i);
          end else begin
            a_v     = 1'b1;
            tok_a   = word_tok(st_q);
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        st_d  = start_state(st_q, ch_i);
        b_v   = start_emits(ch_i);
        tok_b = start_tok(ch_i);
      end
    end
  end

  // Pack the results in order and mark the final one
  always_comb begin
    if (a_v) begin
      first  = tok_a;
      second = tok_b;
      cnt    = b_v ? 2'd2 : 2'd1;
    end else begin
      first  = tok_b;
      second = tok_b;
      cnt    = b_v ? 2'd1 : 2'd0;
    end
    first.last  = (cnt == 2'd1);
    second.last = 1'b1;
    push_o.cnt    = accept_i ? cnt : 2'd0;
    push_o.first  = first;
    push_o.second = second;
  end

  // Advance the lexer state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

`ifndef SYNTHESIS
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_i |=> st_q.mode == MODE_IDLE && st_q.count == '0 && !st_q.ovf)
    else $error("end mark did not return lexer to idle");

  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_i |-> push_o.cnt != 2'd0)
    else $error("end mark produced no end token");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt != 2'd3)
    else $error("more than two results for one request");

  a_idle_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |-> push_o.cnt == 2'd0)
    else $error("results pushed without an accepted request");
`endif

endmodule

`default_nettype wire

// ===== src/cstc_out_queue.sv =====
`default_nettype none

module cstc_out_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cstc_pkg::lex_push_t push_i,
  output logic                     room_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output cstc_pkg::tok_t           tok_o
);

  localparam int unsigned D  = cstc_pkg::QDepth;
  localparam int unsigned PW = cstc_pkg::QPtrW;
  localparam int unsigned FW = cstc_pkg::QFillW;

  cstc_pkg::tok_t  mem_q [D];
  logic [PW-1:0]   wr_q, rd_q;
  logic [FW-1:0]   fill_q, fill_d;
  logic            pop;
  logic [PW-1:0]   wr_next;

  assign room_o  = fill_q <= FW'(D - 2);
  assign valid_o = fill_q != '0;
  assign tok_o   = mem_q[rd_q];
  assign pop     = pop_i && valid_o;
  assign wr_next = wr_q + PW'(1);

  always_comb begin
    fill_d = fill_q + FW'(push_i.cnt) - FW'(pop);
  end

  // Write up to two entries per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_q + PW'(push_i.cnt);
      if (pop) rd_q <= rd_q + PW'(1);
      fill_q <= fill_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(D))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> fill_q <= FW'(D - 2))
    else $error("push without room for two results");

  a_pop_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt == 2'd0 && pop |=> fill_q == $past(fill_q) - FW'(1))
    else $error("pop did not drain the queue");
`endif

endmodule

`default_nettype wire

// ===== src/char_stream_token_classifier.sv =====
`default_nettype none

// Character stream token classifier.
// char_i takes one request per character: ch, or end_of_input to close the
// text (ch is then ignored). tok_o carries one token record per handshake;
// a character can close a pending token and start a new one, so one input
// may give zero, one or two tokens, and last_of_run marks the final one.
// An end mark flushes any pending token, emits an end token and clears
// the lexer back to idle.
// A token is queued by the request that closes it and shows on tok_o once
// earlier tokens are taken. Throughput: one character per cycle while
// ready is high; the lexer updates its state in one step between the input
// handshake and a four-entry result queue, whose room for two tokens sets
// char_i.ready. A stall on tok_o lets the queue fill; char_i keeps accepting
// while two free entries remain, then holds ready low until the receiver
// drains. Reset clears the lexer mode, the length count and the queue; the
// block accepts requests right after reset.

module char_stream_token_classifier (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  cstc_char_if.sink         char_i,
  cstc_tok_if.source        tok_o
);

  logic                 accept;
  logic                 room;
  cstc_pkg::lex_push_t  push;
  cstc_pkg::tok_t       head;

  assign char_i.ready = room;
  assign accept       = char_i.valid && room;

  cstc_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (char_i.ch),
    .end_i    (char_i.end_of_input),
    .push_o   (push)
  );

  cstc_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (tok_o.valid),
    .pop_i   (tok_o.ready),
    .tok_o   (head)
  );

  // Drive the result channel from the queue head
  assign tok_o.token_kind          = head.kind;
  assign tok_o.symbol_code         = head.sym;
  assign tok_o.number_negative     = head.neg;
  assign tok_o.number_has_fraction = head.frac;
  assign tok_o.token_length        = head.len;
  assign tok_o.length_saturated    = head.sat;
  assign tok_o.last_of_run         = head.last;

endmodule

`default_nettype wire
